// ===== rtl/mdsup_pkg.sv =====
`timescale 1ns / 1ps
// mdsup_pkg: supervisor state codes, register indexes and reset values,
// sine polynomial coefficients for the motor drive supervisor.
// no dependencies.
package mdsup_pkg;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_TUNE     = 4'd1;
  localparam logic [3:0] ST_RESET    = 4'd2;
  localparam logic [3:0] ST_OPENLOOP = 4'd3;
  localparam logic [3:0] ST_ENABLE   = 4'd4;
  localparam logic [3:0] ST_DISABLE  = 4'd5;
  localparam logic [3:0] ST_RUNNING  = 4'd6;
  localparam logic [3:0] ST_SHUTDOWN = 4'd7;
  localparam logic [3:0] ST_FAULT    = 4'd8;

  localparam logic [3:0] REG_POLE_PAIRS   = 4'd0;
  localparam logic [3:0] REG_LOCK_MS      = 4'd1;
  localparam logic [3:0] REG_RAMP_MS      = 4'd2;
  localparam logic [3:0] REG_TARGET_RPM   = 4'd3;
  localparam logic [3:0] REG_SETTLE_MS    = 4'd4;
  localparam logic [3:0] REG_SWITCH_SPEED = 4'd5;
  localparam logic [3:0] REG_AMPLITUDE    = 4'd6;
  localparam logic [3:0] REG_PHASE_PER    = 4'd7;

  localparam logic [5:0]  RST_POLE_PAIRS   = 6'd7;
  localparam logic [15:0] RST_LOCK_MS      = 16'd200;
  localparam logic [15:0] RST_RAMP_MS      = 16'd500;
  localparam logic [15:0] RST_TARGET_RPM   = 16'd200;
  localparam logic [15:0] RST_SETTLE_MS    = 16'd200;
  localparam logic [30:0] RST_SWITCH_SPEED = 31'd700;
  localparam logic [14:0] RST_AMPLITUDE    = 15'd32767;
  localparam logic [15:0] RST_PHASE_PER    = 16'd3579;

  localparam logic [16:0] SIN_A = 17'd51472;
  localparam logic [16:0] SIN_B = 17'd21024;
  localparam logic [16:0] SIN_C = 17'd2320;
  localparam logic [16:0] QUARTER = 17'h04000;

endpackage

// ===== rtl/motor_drive_supervisor_open_loop_start.sv =====
`timescale 1ns / 1ps
// motor_drive_supervisor_open_loop_start: nine-state drive supervisor with
// open-loop start ramp, phase accumulator and alpha/beta drive voltages.
// depends on mdsup_pkg.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------------
//   input    | in_valid / in_stall   | req_type .. observer_speed
//   output   | out_valid / out_stall | state_now .. open_loop_angle
//   config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// requests and ticks outside open-loop skip the sequencer; the result is loaded at the
// edge that takes the request.
// an open-loop tick holds the block while the sequencer runs a serial divide during
// the ramp, then the phase update and alpha/beta sines on the one shared multiplier.
// rst is synchronous; it restores register defaults and the idle state.
// a result waiting under out_stall holds the block until it is taken.
module motor_drive_supervisor_open_loop_start
  import mdsup_pkg::*;
#(
  parameter int SINE_TABLE_BITS = 10,
  parameter int RPM_FRAC_BITS   = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               req_type,
  input  logic [3:0]         requested_state,
  input  logic [31:0]        now_ms,
  input  logic               calib_done,
  input  logic               shutdown_done,
  input  logic signed [31:0] observer_speed,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         state_now,
  output logic               pwm_enable,
  output logic               supply_enable,
  output logic               run_inner_loop,
  output logic               core_reset,
  output logic               idle_track,
  output logic               drive_valid,
  output logic signed [15:0] drive_alpha,
  output logic signed [15:0] drive_beta,
  output logic [15:0]        open_loop_angle,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [30:0]        cfg_data
);

  localparam int RW = 16 + RPM_FRAC_BITS;
  localparam int DW = 32 + RPM_FRAC_BITS;
  localparam int MA = RW + 6;
  localparam int PW = MA + 17;
  localparam int CW = $clog2(DW + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RMUL, S_DLOAD, S_DIV, S_PH1, S_PH2, S_PH3, S_ANG,
    S_SQ, S_C1, S_C2, S_C3, S_C4, S_C5, S_OUT
  } seq_t;

  seq_t seq;

  logic [5:0]  pole_pairs;
  logic [15:0] lock_ms, ramp_ms, target_rpm, settle_ms, phase_per_rpm;
  logic [30:0] switch_speed;
  logic [14:0] drive_amplitude;

  logic [3:0]  fsm_state;
  logic        drive_enabled, supply_on;
  logic [31:0] start_time, phase_acc;

  logic [15:0]   dl;
  logic          sw;
  logic [RW-1:0] rpm;
  logic [DW-1:0] dq;
  logic [15:0]   rem;
  logic [CW-1:0] cnt;
  logic [PW-1:0] prod;
  logic [15:0]   z, z2;
  logic [1:0]    quad;
  logic          neg, sel;
  logic [15:0]   alpha_res;
  logic [15:0]   beta_res;

  logic [MA-1:0] mul_a;
  logic [16:0]   mul_b;

  function automatic logic [3:0] gate(input logic [3:0] cur, input logic [3:0] want);
    logic [3:0] r;
    r = want;
    if (want > ST_FAULT) r = cur;
    else if (cur == ST_FAULT && want != ST_RESET) r = cur;
    else if (want == ST_ENABLE && cur != ST_IDLE) r = cur;
    return r;
  endfunction

  function automatic logic [15:0] zval(input logic [15:0] a);
    logic [14:0] q;
    q = {1'b0, a[13:0]};
    if (a[14]) q = 15'(QUARTER) - q;
    return {q, 1'b0};
  endfunction

  logic accept, out_free;
  logic ol_tick, out_load;
  assign out_free  = !out_valid || !out_stall;
  assign accept    = in_valid && !in_stall;
  assign in_stall  = !(seq == S_IDLE && out_free);
  assign cfg_ready = 1'b1;
  assign ol_tick   = !req_type && fsm_state == ST_OPENLOOP;
  assign out_load  = (seq == S_IDLE && accept && !ol_tick) || (seq == S_OUT && out_free);

  // open-loop timing
  logic [31:0] e;
  logic [31:0] lr, lrs, mag;
  assign e   = drive_enabled ? (now_ms - start_time) : 32'd0;
  assign lr  = 32'(lock_ms) + 32'(ramp_ms);
  assign lrs = lr + 32'(settle_ms);
  assign mag = observer_speed[31] ? (32'd0 - observer_speed) : observer_speed;

  logic [15:0] ang;
  assign ang = 16'({phase_acc[31 -: SINE_TABLE_BITS], {(16 - SINE_TABLE_BITS){1'b0}}});

  // quick tick and request actions
  logic [3:0] f_next;
  logic       d_next, s_next, p_inner, p_creset, p_track;
  always_comb begin
    f_next   = fsm_state;
    d_next   = drive_enabled;
    s_next   = supply_on;
    p_inner  = 1'b0;
    p_creset = 1'b0;
    p_track  = 1'b0;
    if (req_type) begin
      f_next = gate(fsm_state, requested_state);
    end else begin
      case (fsm_state)
        ST_IDLE: p_track = 1'b1;
        ST_TUNE: begin
          if (!drive_enabled) begin
            d_next   = 1'b1;
            p_creset = 1'b1;
          end
          if (calib_done) f_next = gate(fsm_state, ST_DISABLE);
          p_inner = 1'b1;
        end
        ST_RESET: begin
          p_creset = 1'b1;
          f_next   = gate(fsm_state, ST_IDLE);
          d_next   = 1'b0;
          s_next   = 1'b1;
        end
        ST_ENABLE: begin
          d_next = 1'b1;
          f_next = gate(fsm_state, ST_RUNNING);
        end
        ST_DISABLE: begin
          d_next = 1'b0;
          f_next = gate(fsm_state, ST_RESET);
        end
        ST_RUNNING: p_inner = 1'b1;
        ST_SHUTDOWN: if (shutdown_done) f_next = gate(fsm_state, ST_FAULT);
        ST_FAULT: begin
          if (drive_enabled) begin
            d_next = 1'b0;
            s_next = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (seq)
      S_RMUL: begin mul_a = MA'(dl);             mul_b = 17'(target_rpm); end
      S_PH1:  begin mul_a = MA'(rpm);            mul_b = 17'(pole_pairs); end
      S_PH2:  begin mul_a = prod[MA-1:0];        mul_b = 17'(phase_per_rpm); end
      S_SQ:   begin mul_a = MA'(z);              mul_b = 17'(z); end
      S_C1:   begin mul_a = MA'(prod[30:15]);    mul_b = SIN_C; end
      S_C2:   begin mul_a = MA'(z2);             mul_b = SIN_B - 17'(prod[30:15]); end
      S_C3:   begin mul_a = MA'(z);              mul_b = SIN_A - 17'(prod[30:15]); end
      S_C4: begin
        mul_a = MA'(drive_amplitude);
        mul_b = (prod[31:15] > 17'd32767) ? 17'd32767 : 17'(prod[31:15]);
      end
      default: ;
    endcase
  end

  logic [16:0] rem_sh;
  logic        rem_ge;
  assign rem_sh = {rem, dq[DW-1]};
  assign rem_ge = rem_sh >= {1'b0, ramp_ms};

  logic [14:0] v;
  logic [15:0] vres;
  assign v    = prod[29:15];
  assign vres = neg ? (16'd0 - {1'b0, v}) : {1'b0, v};

  always_ff @(posedge clk) begin
    if (rst) begin
      seq             <= S_IDLE;
      pole_pairs      <= RST_POLE_PAIRS;
      lock_ms         <= RST_LOCK_MS;
      ramp_ms         <= RST_RAMP_MS;
      target_rpm      <= RST_TARGET_RPM;
      settle_ms       <= RST_SETTLE_MS;
      switch_speed    <= RST_SWITCH_SPEED;
      drive_amplitude <= RST_AMPLITUDE;
      phase_per_rpm   <= RST_PHASE_PER;
      fsm_state       <= ST_IDLE;
      drive_enabled   <= 1'b0;
      supply_on       <= 1'b1;
      start_time      <= '0;
      phase_acc       <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_POLE_PAIRS:   pole_pairs      <= cfg_data[5:0];
          REG_LOCK_MS:      lock_ms         <= cfg_data[15:0];
          REG_RAMP_MS:      ramp_ms         <= cfg_data[15:0];
          REG_TARGET_RPM:   target_rpm      <= cfg_data[15:0];
          REG_SETTLE_MS:    settle_ms       <= cfg_data[15:0];
          REG_SWITCH_SPEED: switch_speed    <= cfg_data;
          REG_AMPLITUDE:    drive_amplitude <= cfg_data[14:0];
          REG_PHASE_PER:    phase_per_rpm   <= cfg_data[15:0];
          default: ;
        endcase
      end

      out_valid <= out_load || (out_valid && out_stall);

      prod <= PW'(mul_a) * PW'(mul_b);

      case (seq)
        S_IDLE: begin
          if (accept) begin
            if (ol_tick) begin
              if (!drive_enabled) begin
                drive_enabled <= 1'b1;
                start_time    <= now_ms;
                phase_acc     <= '0;
              end
              sw <= (e > lrs) && (mag > 32'(switch_speed));
              dl <= 16'(e - 32'(lock_ms));
              if (e < 32'(lock_ms)) begin
                rpm <= '0;
                seq <= S_PH1;
              end else if (e < lr) begin
                seq <= S_RMUL;
              end else begin
                rpm <= RW'(target_rpm) << RPM_FRAC_BITS;
                seq <= S_PH1;
              end
            end else begin
              fsm_state       <= f_next;
              drive_enabled   <= d_next;
              supply_on       <= s_next;
              state_now       <= f_next;
              pwm_enable      <= d_next;
              supply_enable   <= s_next;
              run_inner_loop  <= p_inner;
              core_reset      <= p_creset;
              idle_track      <= p_track;
              drive_valid     <= 1'b0;
              drive_alpha     <= '0;
              drive_beta      <= '0;
              open_loop_angle <= phase_acc[31:16];
            end
          end
        end
        S_RMUL: seq <= S_DLOAD;
        S_DLOAD: begin
          dq  <= DW'(prod[31:0]) << RPM_FRAC_BITS;
          rem <= '0;
          cnt <= '0;
          seq <= S_DIV;
        end
        S_DIV: begin
          rem <= rem_ge ? 16'(rem_sh - {1'b0, ramp_ms}) : rem_sh[15:0];
          dq  <= {dq[DW-2:0], rem_ge};
          cnt <= cnt + 1'b1;
          if (cnt == CW'(DW - 1)) begin
            rpm <= RW'({dq[DW-2:0], rem_ge});
            seq <= S_PH1;
          end
        end
        S_PH1: seq <= S_PH2;
        S_PH2: seq <= S_PH3;
        S_PH3: begin
          phase_acc <= phase_acc + prod[RPM_FRAC_BITS +: 32];
          seq       <= S_ANG;
        end
        S_ANG: begin
          z    <= zval(ang + 16'(QUARTER));
          quad <= 2'((ang + 16'(QUARTER)) >> 14);
          sel  <= 1'b0;
          seq  <= S_SQ;
        end
        S_SQ: seq <= S_C1;
        S_C1: begin
          z2  <= prod[30:15];
          seq <= S_C2;
        end
        S_C2: seq <= S_C3;
        S_C3: seq <= S_C4;
        S_C4: begin
          neg <= quad[1] && (prod[31:15] != 17'd0);
          seq <= S_C5;
        end
        S_C5: begin
          if (!sel) begin
            alpha_res <= vres;
            z         <= zval(ang);
            quad      <= ang[15:14];
            sel       <= 1'b1;
            seq       <= S_SQ;
          end else begin
            beta_res <= vres;
            seq      <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            fsm_state       <= sw ? gate(fsm_state, ST_RUNNING) : fsm_state;
            state_now       <= sw ? gate(fsm_state, ST_RUNNING) : fsm_state;
            pwm_enable      <= drive_enabled;
            supply_enable   <= supply_on;
            run_inner_loop  <= 1'b0;
            core_reset      <= 1'b0;
            idle_track      <= 1'b0;
            drive_valid     <= 1'b1;
            drive_alpha     <= alpha_res;
            drive_beta      <= beta_res;
            open_loop_angle <= phase_acc[31:16];
            seq             <= S_IDLE;
          end
        end
        default: seq <= S_IDLE;
      endcase
    end
  end

  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    seq != S_IDLE |-> in_stall) else $error("busy but not stalling");
  a_state_range: assert property (@(posedge clk) disable iff (rst)
    fsm_state <= ST_FAULT) else $error("supervisor state out of range");
  a_drive_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && drive_valid |-> state_now == ST_OPENLOOP || state_now == ST_RUNNING)
    else $error("drive voltages outside open loop");
  a_div_ramp: assert property (@(posedge clk) disable iff (rst)
    seq == S_DIV |-> ramp_ms != 16'd0) else $error("divide by zero ramp");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("stalled result dropped");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking bench for motor_drive_supervisor_open_loop_start, with its
// own state/ramp/sine predictor, directed table then episode-based random ticks.
// depends on mdsup_pkg and the supervisor rtl.
module tb;
  import mdsup_pkg::*;

  localparam int LIMIT = 3000000;

  typedef struct packed {
    logic        req;
    logic [3:0]  want;
    logic [31:0] now;
    logic        calib;
    logic        sdone;
    logic [31:0] obs;
  } tick_t;

  typedef struct packed {
    logic [3:0]  st;
    logic        pwm;
    logic        sup;
    logic        inner;
    logic        crst;
    logic        trk;
    logic        dv;
    logic [15:0] alpha;
    logic [15:0] beta;
    logic [15:0] angle;
  } drive_t;

  typedef struct packed {
    logic       chk;
    logic [3:0] st;
    logic       pwm;
    logic       sup;
    logic       inner;
    logic       crst;
    logic       trk;
  } typed_t;

  typedef struct packed {
    tick_t  t;
    typed_t c;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic req_type = 0;
  logic [3:0] requested_state = 0;
  logic [31:0] now_ms = 0;
  logic calib_done = 0;
  logic shutdown_done = 0;
  logic signed [31:0] observer_speed = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [3:0] state_now;
  logic pwm_enable, supply_enable, run_inner_loop, core_reset, idle_track, drive_valid;
  logic signed [15:0] drive_alpha, drive_beta;
  logic [15:0] open_loop_angle;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [3:0] cfg_index = 0;
  logic [30:0] cfg_data = 0;

  motor_drive_supervisor_open_loop_start dut (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // predictor state
  logic [30:0] regs_q [8];
  logic [3:0]  sup_state;
  logic        drv_on;
  logic [31:0] ol_start;
  logic [31:0] phase_acc;
  logic        supply_on;

  drive_t drive_q[$];
  typed_t typed_q[$];
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_ol_ticks = 0;
  int n_switch = 0;
  int cycles = 0;
  int hold_cnt = 0;
  bit hold_req = 0;
  int burst_left = 0;
  logic [31:0] now_t = 0;

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want, n_results);
  endtask

  function automatic logic [15:0] sine_scaled(input logic [15:0] ang);
    int unsigned q, z, z2, t, s, v;
    logic [1:0] quad;
    quad = ang[15:14];
    q = 32'(ang[13:0]);
    if (quad[0]) q = 32'h4000 - q;
    z = q << 1;
    z2 = (z * z) >> 15;
    t = (32'd2320 * z2) >> 15;
    t = 32'd21024 - t;
    t = (z2 * t) >> 15;
    t = 32'd51472 - t;
    s = (z * t) >> 15;
    if (s > 32767) s = 32767;
    v = (32'(regs_q[REG_AMPLITUDE]) * s) >> 15;
    if (quad[1] && s != 0) v = -v;
    return v[15:0];
  endfunction

  task automatic goto_state(input logic [3:0] w);
    if (w > ST_FAULT) return;
    if (sup_state == ST_FAULT && w != ST_RESET) return;
    if (w == ST_ENABLE && sup_state != ST_IDLE) return;
    sup_state = w;
  endtask

  task automatic predict_drive(input tick_t it, output drive_t r);
    longint unsigned e, lock, ramp, tgt, rpm, mag;
    logic [31:0] el;
    logic [15:0] ang;
    r = '0;
    if (it.req) begin
      goto_state(it.want);
    end else begin
      case (sup_state)
        ST_IDLE: r.trk = 1;
        ST_TUNE: begin
          if (!drv_on) begin
            drv_on = 1;
            r.crst = 1;
          end
          if (it.calib) goto_state(ST_DISABLE);
          r.inner = 1;
        end
        ST_RESET: begin
          r.crst = 1;
          goto_state(ST_IDLE);
          drv_on = 0;
          supply_on = 1;
        end
        ST_OPENLOOP: begin
          n_ol_ticks++;
          lock = regs_q[REG_LOCK_MS];
          ramp = regs_q[REG_RAMP_MS];
          tgt = regs_q[REG_TARGET_RPM];
          if (!drv_on) begin
            drv_on = 1;
            ol_start = it.now;
            phase_acc = 0;
          end
          el = it.now - ol_start;
          e = el;
          if (e < lock) rpm = 0;
          else if (e < lock + ramp) rpm = ((tgt * (e - lock)) << 8) / ramp;
          else rpm = tgt << 8;
          phase_acc = phase_acc + 32'((rpm * regs_q[REG_POLE_PAIRS] *
                                       regs_q[REG_PHASE_PER]) >> 8);
          ang = {phase_acc[31:22], 6'd0};
          r.alpha = sine_scaled(ang + 16'h4000);
          r.beta = sine_scaled(ang);
          r.dv = 1;
          if (e > lock + ramp + regs_q[REG_SETTLE_MS]) begin
            mag = it.obs[31] ? (64'h1_0000_0000 - it.obs) : it.obs;
            if (mag > regs_q[REG_SWITCH_SPEED]) begin
              goto_state(ST_RUNNING);
              n_switch++;
            end
          end
        end
        ST_ENABLE: begin
          drv_on = 1;
          goto_state(ST_RUNNING);
        end
        ST_DISABLE: begin
          drv_on = 0;
          goto_state(ST_RESET);
        end
        ST_RUNNING: r.inner = 1;
        ST_SHUTDOWN: if (it.sdone) goto_state(ST_FAULT);
        ST_FAULT: begin
          if (drv_on) begin
            drv_on = 0;
            supply_on = 0;
          end
        end
        default: ;
      endcase
    end
    r.st = sup_state;
    r.pwm = drv_on;
    r.sup = supply_on;
    r.angle = phase_acc[31:16];
  endtask

  task automatic check_field(input string what, input longint got, input longint want);
    if (got != want) report(what, got, want);
  endtask

  // request and result monitor
  always @(posedge clk) begin
    tick_t it;
    drive_t r;
    typed_t c;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        it = '{req_type, requested_state, now_ms, calib_done, shutdown_done, observer_speed};
        predict_drive(it, r);
        c = typed_q.pop_front();
        if (c.chk) begin
          r.st = c.st;
          r.pwm = c.pwm;
          r.sup = c.sup;
          r.inner = c.inner;
          r.crst = c.crst;
          r.trk = c.trk;
        end
        drive_q.push_back(r);
      end
      if (out_valid && !out_stall) begin
        n_results++;
        if (drive_q.size() == 0) begin
          report("unexpected result", state_now, 0);
        end else begin
          r = drive_q.pop_front();
          check_field("state_now", state_now, r.st);
          check_field("pwm_enable", pwm_enable, r.pwm);
          check_field("supply_enable", supply_enable, r.sup);
          check_field("run_inner_loop", run_inner_loop, r.inner);
          check_field("core_reset", core_reset, r.crst);
          check_field("idle_track", idle_track, r.trk);
          check_field("drive_valid", drive_valid, r.dv);
          check_field("drive_alpha", $unsigned(drive_alpha), r.alpha);
          check_field("drive_beta", $unsigned(drive_beta), r.beta);
          check_field("open_loop_angle", open_loop_angle, r.angle);
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off on request
  always @(posedge clk) begin
    int mode;
    mode = (cycles / 64) % 4;
    if (hold_req) begin
      hold_cnt = 600;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1;
    end else begin
      case (mode)
        0: out_stall <= 0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= cycles[0];
      endcase
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send(input tick_t it, input typed_t c);
    typed_q.push_back(c);
    req_type <= it.req;
    requested_state <= it.want;
    now_ms <= it.now;
    calib_done <= it.calib;
    shutdown_done <= it.sdone;
    observer_speed <= it.obs;
    in_valid <= 1;
    n_items++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      int gap;
      gap = $urandom_range(1, 12);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(0, 15);
    end
  endtask

  task automatic send_req(input logic [3:0] w);
    send('{1'b1, w, now_t, 1'b0, 1'b0, 32'd0}, '0);
  endtask

  task automatic send_tick(input logic [31:0] obs, input logic calib, input logic sdone);
    send('{1'b0, 4'(ST_IDLE), now_t, calib, sdone, obs}, '0);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (drive_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_regs(input logic [30:0] v [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_index <= i[3:0];
      cfg_data <= v[i];
      cfg_valid <= 1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (i[3:0])
        REG_POLE_PAIRS: regs_q[i] = 31'(v[i][5:0]);
        REG_SWITCH_SPEED: regs_q[i] = v[i];
        REG_AMPLITUDE: regs_q[i] = 31'(v[i][14:0]);
        default: regs_q[i] = 31'(v[i][15:0]);
      endcase
    end
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_obs();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 2000);
      3: return -$urandom_range(0, 2000);
      default: return $urandom;
    endcase
  endfunction

  // well-formed open-loop starts, tune or enable episodes, and random noise
  task automatic run_random(input int quota);
    int stop;
    longint unsigned span;
    int step, m;
    stop = n_items + quota;
    while (n_items < stop) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          span = regs_q[REG_LOCK_MS] + regs_q[REG_RAMP_MS] + regs_q[REG_SETTLE_MS];
          step = int'(span / 20) + 1;
          if ($urandom_range(0, 9) == 0) now_t = 32'hFFFF_FFFF - $urandom_range(0, 3 * step);
          send_req(ST_RESET);
          send_tick(rand_obs(), 0, 0);
          send_req(ST_OPENLOOP);
          m = $urandom_range(8, 32);
          repeat (m) begin
            now_t += $urandom_range(0, 2 * step);
            if ($urandom_range(0, 29) == 0) send_req(4'($urandom_range(0, 15)));
            else send_tick(rand_obs(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          end
          send_req(ST_SHUTDOWN);
          repeat (3) send_tick(rand_obs(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        6, 7: begin
          send_req(ST_RESET);
          send_tick(rand_obs(), 0, 0);
          send_req($urandom_range(0, 1) ? ST_TUNE : ST_ENABLE);
          repeat (5) send_tick(rand_obs(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        default: begin
          repeat (10) begin
            now_t = $urandom;
            send('{1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), now_t,
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rand_obs()}, '0);
          end
        end
      endcase
    end
  endtask

  row_t dir_rows [] = '{
    '{'{0, ST_IDLE, 32'd0, 0, 0, 32'd0}, '{1, ST_IDLE, 0, 1, 0, 0, 1}},
    '{'{1, 4'd15, 32'd0, 0, 0, 32'd0}, '{1, ST_IDLE, 0, 1, 0, 0, 0}},
    '{'{1, ST_FAULT, 32'd0, 0, 0, 32'd0}, '{1, ST_FAULT, 0, 1, 0, 0, 0}},
    '{'{1, ST_IDLE, 32'd0, 0, 0, 32'd0}, '{1, ST_FAULT, 0, 1, 0, 0, 0}},
    '{'{1, ST_RESET, 32'd0, 0, 0, 32'd0}, '{1, ST_RESET, 0, 1, 0, 0, 0}},
    '{'{0, ST_IDLE, 32'd0, 0, 0, 32'd0}, '{1, ST_IDLE, 0, 1, 0, 1, 0}},
    '{'{1, ST_ENABLE, 32'd0, 0, 0, 32'd0}, '{1, ST_ENABLE, 0, 1, 0, 0, 0}},
    '{'{0, ST_IDLE, 32'd0, 0, 0, 32'd0}, '{1, ST_RUNNING, 1, 1, 0, 0, 0}},
    '{'{1, ST_ENABLE, 32'd0, 0, 0, 32'd0}, '{1, ST_RUNNING, 1, 1, 0, 0, 0}},
    '{'{0, ST_IDLE, 32'd0, 0, 0, 32'd0}, '{1, ST_RUNNING, 1, 1, 1, 0, 0}},
    '{'{1, ST_SHUTDOWN, 32'd0, 0, 0, 32'd0}, '{1, ST_SHUTDOWN, 1, 1, 0, 0, 0}},
    '{'{0, ST_IDLE, 32'd0, 1, 0, 32'd0}, '{1, ST_SHUTDOWN, 1, 1, 0, 0, 0}},
    '{'{0, ST_IDLE, 32'd0, 0, 1, 32'd0}, '{1, ST_FAULT, 1, 1, 0, 0, 0}},
    '{'{0, ST_IDLE, 32'd0, 0, 0, 32'd0}, '{1, ST_FAULT, 0, 0, 0, 0, 0}},
    '{'{1, ST_RESET, 32'd0, 0, 0, 32'd0}, '{1, ST_RESET, 0, 0, 0, 0, 0}},
    '{'{0, ST_IDLE, 32'd0, 0, 0, 32'd0}, '{1, ST_IDLE, 0, 1, 0, 1, 0}},
    '{'{1, ST_TUNE, 32'd0, 0, 0, 32'd0}, '{1, ST_TUNE, 0, 1, 0, 0, 0}},
    '{'{0, ST_IDLE, 32'd0, 0, 0, 32'd0}, '{1, ST_TUNE, 1, 1, 1, 1, 0}},
    '{'{0, ST_IDLE, 32'd0, 1, 0, 32'd0}, '{1, ST_DISABLE, 1, 1, 1, 0, 0}},
    '{'{0, ST_IDLE, 32'd0, 0, 0, 32'd0}, '{1, ST_RESET, 0, 1, 0, 0, 0}},
    '{'{0, ST_IDLE, 32'd0, 0, 0, 32'd0}, '{1, ST_IDLE, 0, 1, 0, 1, 0}},
    '{'{1, ST_OPENLOOP, 32'd0, 0, 0, 32'd0}, '{1, ST_OPENLOOP, 0, 1, 0, 0, 0}},
    '{'{0, ST_IDLE, 32'hFFFF_FF00, 0, 0, 32'h7FFF_FFFF}, '0},
    '{'{0, ST_IDLE, 32'h0000_0010, 0, 0, 32'd0}, '0},
    '{'{0, ST_IDLE, 32'h0000_0100, 0, 0, 32'd0}, '0},
    '{'{0, ST_IDLE, 32'h0000_1000, 0, 0, 32'h8000_0000}, '{1, ST_RUNNING, 1, 1, 0, 0, 0}}
  };

  logic [30:0] cfg_min [8] = '{31'd1, 31'd0, 31'd1, 31'd65535, 31'd0, 31'd0, 31'd32767,
                               31'd65535};
  logic [30:0] cfg_max [8] = '{31'd32, 31'd65535, 31'd65535, 31'd65535, 31'd65535,
                               31'h7FFF_FFFF, 31'd0, 31'd65535};
  logic [30:0] cfg_rnd [8];

  initial begin
    regs_q = '{31'(RST_POLE_PAIRS), 31'(RST_LOCK_MS), 31'(RST_RAMP_MS),
               31'(RST_TARGET_RPM), 31'(RST_SETTLE_MS), RST_SWITCH_SPEED,
               31'(RST_AMPLITUDE), 31'(RST_PHASE_PER)};
    sup_state = ST_IDLE;
    drv_on = 0;
    ol_start = 0;
    phase_acc = 0;
    supply_on = 1;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (dir_rows[i]) send(dir_rows[i].t, dir_rows[i].c);
    run_random(300);
    drain();

    write_regs(cfg_min);
    run_random(250);
    drain();

    write_regs(cfg_max);
    hold_req = 1;
    run_random(250);
    drain();

    for (int p = 0; p < 3; p++) begin
      cfg_rnd = '{31'($urandom_range(1, 32)), 31'($urandom_range(0, 300)),
                  31'($urandom_range(0, 1) ? $urandom_range(1, 400) : $urandom_range(1, 65535)),
                  31'($urandom_range(0, 65535)), 31'($urandom_range(0, 300)),
                  31'($urandom_range(0, 1) ? $urandom_range(0, 5000) : $urandom),
                  31'($urandom_range(0, 32767)), 31'($urandom_range(0, 65535))};
      write_regs(cfg_rnd);
      run_random(300);
      drain();
    end

    $display("%0d requests, %0d results, %0d open-loop ticks, %0d closed-loop handovers",
             n_items, n_results, n_ol_ticks, n_switch);
    $display("six register settings including both extremes, one long output hold-off");
    if (errors == 0 && typed_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
